[rtl/core/tdrt_pkg.sv]
// Shared types, codes and default sizes for the tiled dirty region tracker.
`timescale 1ns / 1ps
`default_nettype none
package tdrt_pkg;

	// default geometry
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 256;
	localparam int TILES_ACROSS_DEF  = 8;
	localparam int TILES_DOWN_DEF    = 8;

	// tile index width covers the largest grid (16 tiles per axis)
	localparam int IDX_W   = 4;
	// results per flush
	localparam int MAX_RES = 64;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	// request codes
	localparam logic [2:0] REQ_POINT = 3'd0;
	localparam logic [2:0] REQ_RECT  = 3'd1;
	localparam logic [2:0] REQ_FLUSH = 3'd2;
	localparam logic [2:0] REQ_ALL   = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// tile walk kinds
	localparam logic [1:0] WK_UPD  = 2'd0;
	localparam logic [1:0] WK_FULL = 2'd1;
	localparam logic [1:0] WK_CHK  = 2'd2;
	localparam logic [1:0] WK_SCAN = 2'd3;

	typedef struct packed {
		logic       load_req;
		logic       grow;
		logic       rd_en;
		logic       wr_en;
		logic       scan_init;
		logic       scan_take;
		logic       emit_fin;
		logic       emit_glob;
		logic       clear_all;
		logic [1:0] mode;
	} tdrt_cmd_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic             point_ok;
		logic             rect_ok;
		logic             solid_cand;
		logic             tile_full;
		logic             tile_nonempty;
		logic             out_free;
		logic             pend_v;
		logic             cnt_last;
		logic [IDX_W-1:0] ilo;
		logic [IDX_W-1:0] ihi;
		logic [IDX_W-1:0] jlo;
		logic [IDX_W-1:0] jhi;
	} tdrt_stat_t;

endpackage
`default_nettype wire

[rtl/core/tiled_dirty_region_tracker_core.sv]
// Top level of the tiled dirty region tracker.
//
// Input channel s_*: one request per transfer, kind in s_tuser, coordinates
// in s_tdata. Output channel m_*: one redraw region per transfer, has_region
// in m_tuser, m_tlast on the final region of a flush. Only flush produces
// results. A point mark or a rectangle mark reads and rewrites each touched
// tile; a point off screen or an empty rectangle touches no tile; mark all
// rewrites every tile and clear resets them all at once. Flush scans the
// tiles and then gives the final result; when the global box spans enough
// tiles the interior is checked first, and a failed check falls back to the
// full scan. The single-port tile memory is read and then evaluated for
// each tile in turn.
// One request is in work at a time; s_tready is high only between requests.
// Results pass through an output register; a stalled receiver holds the
// walk until that register frees, and the next request is taken while the
// last result still waits.
// Reset clears all tiles at once through per-tile valid bits and empties
// the global box; no sweep follows reset.
`timescale 1ns / 1ps
`default_nettype none
module tiled_dirty_region_tracker_core
	import tdrt_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TILES_ACROSS  = TILES_ACROSS_DEF,
	parameter int TILES_DOWN    = TILES_DOWN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // pos_x, pos_y, rect_w, rect_h
	input  wire logic [2:0]  s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // region_id, left, top, right, bottom
	output logic             m_tuser,  // has_region
	output logic             m_tlast   // last
);

	tdrt_cmd_t        cmd;
	tdrt_stat_t       st;
	logic [IDX_W-1:0] i_idx, j_idx;

	tdrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd),
		.i_idx    (i_idx),
		.j_idx    (j_idx)
	);

	tdrt_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TILES_ACROSS  (TILES_ACROSS),
		.TILES_DOWN    (TILES_DOWN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.i_idx    (i_idx),
		.j_idx    (j_idx),
		.cmd      (cmd),
		.st       (st)
	);

endmodule
`default_nettype wire

[rtl/core/tdrt_ctrl.sv]
// Controller: sequences requests and walks the tile grid.
`timescale 1ns / 1ps
`default_nettype none
module tdrt_ctrl
	import tdrt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire tdrt_stat_t st,
	output tdrt_cmd_t       cmd,
	output logic [IDX_W-1:0] i_idx,
	output logic [IDX_W-1:0] j_idx
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_INIT = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EV   = 3'd4;
	localparam logic [2:0] S_GLOB = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [1:0]       mode_q, mode_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
	logic             done;

	assign s_tready = (state_q == S_IDLE);
	assign i_idx    = i_q;
	assign j_idx    = j_q;
	assign done     = (i_q == st.ihi) && (j_q == st.jhi);

	// next state and commands
	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		state_d  = state_q;
		mode_d   = mode_q;
		i_d      = i_q;
		j_d      = j_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_PREP;
				end
			end
			S_PREP: begin
				state_d = S_IDLE;
				unique case (st.req_type)
					REQ_POINT: begin
						if (st.point_ok) begin
							cmd.grow = 1'b1;
							mode_d   = WK_UPD;
							state_d  = S_INIT;
						end
					end
					REQ_RECT: begin
						if (st.rect_ok) begin
							cmd.grow = 1'b1;
							mode_d   = WK_UPD;
							state_d  = S_INIT;
						end
					end
					REQ_FLUSH: begin
						cmd.scan_init = 1'b1;
						mode_d        = st.solid_cand ? WK_CHK : WK_SCAN;
						state_d       = S_INIT;
					end
					REQ_ALL: begin
						cmd.grow = 1'b1;
						mode_d   = WK_FULL;
						state_d  = S_INIT;
					end
					REQ_CLEAR: cmd.clear_all = 1'b1;
					default: state_d = S_IDLE;
				endcase
			end
			S_INIT: begin
				i_d     = st.ilo;
				j_d     = st.jlo;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EV;
			end
			S_EV: begin
				unique case (mode_q)
					WK_UPD, WK_FULL: begin
						cmd.wr_en = 1'b1;
						state_d   = done ? S_IDLE : S_RD;
					end
					WK_CHK: begin
						if (!st.tile_full) begin
							mode_d  = WK_SCAN;
							state_d = S_INIT;
						end else begin
							state_d = done ? S_GLOB : S_RD;
						end
					end
					default: begin
						if (st.tile_nonempty && st.pend_v && !st.out_free) begin
							state_d = S_EV;
						end else if (st.tile_nonempty) begin
							cmd.scan_take = 1'b1;
							state_d       = (st.cnt_last || done) ? S_FIN : S_RD;
						end else begin
							state_d = done ? S_FIN : S_RD;
						end
					end
				endcase
				// row-major step, columns inner
				if (state_d == S_RD) begin
					if (i_q == st.ihi) begin
						i_d = st.ilo;
						j_d = j_q + 1'b1;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			S_GLOB: begin
				if (st.out_free) begin
					cmd.emit_glob = 1'b1;
					cmd.clear_all = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit_fin  = 1'b1;
					cmd.clear_all = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= WK_UPD;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/tdrt_datapath.sv]
// Datapath: request clipping, tile store, global box and result registers.
`timescale 1ns / 1ps
`default_nettype none
module tdrt_datapath
	import tdrt_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TILES_ACROSS  = TILES_ACROSS_DEF,
	parameter int TILES_DOWN    = TILES_DOWN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [47:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [47:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast,
	input  wire logic [IDX_W-1:0] i_idx,
	input  wire logic [IDX_W-1:0] j_idx,
	input  wire tdrt_cmd_t   cmd,
	output tdrt_stat_t       st
);

	localparam int XS   = (SCREEN_WIDTH / TILES_ACROSS > 0) ? SCREEN_WIDTH / TILES_ACROSS : 1;
	localparam int YS   = (SCREEN_HEIGHT / TILES_DOWN > 0) ? SCREEN_HEIGHT / TILES_DOWN : 1;
	localparam int MAXD = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int CW   = $clog2(MAXD + 1);
	localparam int NT   = TILES_ACROSS * TILES_DOWN;
	localparam int KW   = (NT > 1) ? $clog2(NT) : 1;
	localparam int BW   = 4 * CW;
	localparam logic signed [13:0] SW_S = 14'(SCREEN_WIDTH);
	localparam logic signed [13:0] SH_S = 14'(SCREEN_HEIGHT);
	localparam logic [CW-1:0]      SW_C = CW'(SCREEN_WIDTH);
	localparam logic [CW-1:0]      SH_C = CW'(SCREEN_HEIGHT);

	function automatic logic [IDX_W-1:0] col_of(input logic [CW-1:0] v);
		logic [IDX_W-1:0] c;
		c = '0;
		for (int n = 1; n < TILES_ACROSS; n++) if (int'(v) >= n * XS) c = IDX_W'(n);
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] row_of(input logic [CW-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int n = 1; n < TILES_DOWN; n++) if (int'(v) >= n * YS) r = IDX_W'(n);
		return r;
	endfunction

	// one axis of a tile update; tend is one past the tile's last pixel
	function automatic logic [2*CW-1:0] axis_upd(
		input logic [CW-1:0] lo_in, hi_in, s, e, tmin, tend,
		input logic first, lastc, pt, full
	);
		logic [CW-1:0] lo, hi;
		lo = lo_in;
		hi = hi_in;
		if (full) begin
			lo = tmin;
			hi = tend;
		end else if (pt) begin
			if (s < lo) lo = s;
			if (e > hi) hi = e;
		end else begin
			if (first) begin
				if (s < lo) lo = s;
				if (e >= tend) hi = tend;
			end
			if (lastc) begin
				if (e > hi) hi = e;
				if (s < tmin) lo = tmin;
			end
			if (!first && !lastc) begin
				lo = tmin;
				hi = tend;
			end
		end
		return {lo, hi};
	endfunction

	function automatic logic [8:0] to9(input logic [CW-1:0] v);
		logic [CW+8:0] t;
		t = (CW + 9)'(v);
		return t[8:0];
	endfunction

	// result item: id, left, top, right, bottom, has_region from the lowest bit up
	function automatic logic [43:0] pack_item(
		input logic [6:0] id, input logic [8:0] l, t, r, b, input logic has
	);
		return {has, b, r, t, l, id};
	endfunction

	// request capture
	logic [2:0]         req_type_q;
	logic signed [11:0] px_q, py_q, pw_q, ph_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= s_tuser;
			px_q       <= s_tdata[11:0];
			py_q       <= s_tdata[23:12];
			pw_q       <= s_tdata[35:24];
			ph_q       <= s_tdata[47:36];
		end
	end

	// clipping of the point or rectangle to the screen
	logic signed [13:0] px, py, xsum, ysum, xs_c, xe_c, ys_c, ye_c;
	logic               is_point, x_ok, y_ok;
	logic [CW-1:0]      xs_u, xe_u, ys_u, ye_u;

	assign px       = 14'(px_q);
	assign py       = 14'(py_q);
	assign xsum     = px + 14'(pw_q);
	assign ysum     = py + 14'(ph_q);
	assign xs_c     = (px < 0) ? 14'sd0 : px;
	assign ys_c     = (py < 0) ? 14'sd0 : py;
	assign xe_c     = (xsum > SW_S) ? SW_S : xsum;
	assign ye_c     = (ysum > SH_S) ? SH_S : ysum;
	assign x_ok     = xe_c > xs_c;
	assign y_ok     = ye_c > ys_c;
	assign is_point = (req_type_q == REQ_POINT);
	assign xs_u     = is_point ? CW'(px) : CW'(xs_c);
	assign ys_u     = is_point ? CW'(py) : CW'(ys_c);
	assign xe_u     = is_point ? CW'(px + 14'sd1) : CW'(xe_c);
	assign ye_u     = is_point ? CW'(py + 14'sd1) : CW'(ye_c);

	// global dirty box
	logic [CW-1:0] g_l_q, g_r_q, g_t_q, g_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_l_q <= SW_C;
			g_r_q <= '0;
			g_t_q <= SH_C;
			g_b_q <= '0;
		end else if (cmd.clear_all) begin
			g_l_q <= SW_C;
			g_r_q <= '0;
			g_t_q <= SH_C;
			g_b_q <= '0;
		end else if (cmd.grow) begin
			if (req_type_q == REQ_ALL) begin
				g_l_q <= '0;
				g_r_q <= SW_C;
				g_t_q <= '0;
				g_b_q <= SH_C;
			end else begin
				if (xs_u < g_l_q) g_l_q <= xs_u;
				if (xe_u > g_r_q) g_r_q <= xe_u;
				if (ys_u < g_t_q) g_t_q <= ys_u;
				if (ye_u > g_b_q) g_b_q <= ye_u;
			end
		end
	end

	// tile ranges for the current walk
	logic [IDX_W-1:0] cl, cr, rt, rb;
	logic [IDX_W-1:0] ilo, ihi, jlo, jhi;
	logic             solid_cand;

	assign cl = col_of(g_l_q);
	assign cr = col_of(g_r_q);
	assign rt = row_of(g_t_q);
	assign rb = row_of(g_b_q);
	assign solid_cand = (g_l_q < g_r_q) && (g_t_q < g_b_q)
		&& ({1'b0, cl} + (IDX_W + 1)'(2) < {1'b0, cr})
		&& ({1'b0, rt} + (IDX_W + 1)'(2) < {1'b0, rb});

	always_comb begin
		unique case (cmd.mode)
			WK_UPD: begin
				ilo = col_of(xs_u);
				jlo = row_of(ys_u);
				ihi = is_point ? ilo : col_of(xe_u);
				jhi = is_point ? jlo : row_of(ye_u);
			end
			WK_CHK: begin
				ilo = cl + 1'b1;
				ihi = cr - 1'b1;
				jlo = rt + 1'b1;
				jhi = rb - 1'b1;
			end
			default: begin
				ilo = '0;
				ihi = IDX_W'(TILES_ACROSS - 1);
				jlo = '0;
				jhi = IDX_W'(TILES_DOWN - 1);
			end
		endcase
	end

	// tile store, column-major address; entries never written read as empty
	logic [BW-1:0] mem [NT];
	logic [BW-1:0] rd_q;
	logic [NT-1:0] vld_q;
	logic          rd_vld_q;
	logic [KW-1:0] k;
	logic [BW-1:0] box, wbox;

	assign k = KW'(int'(i_idx) * TILES_DOWN + int'(j_idx));

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[k] <= wbox;
		if (cmd.rd_en) rd_q <= mem[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.rd_en) rd_vld_q <= vld_q[k];
			if (cmd.clear_all) vld_q <= '0;
			else if (cmd.wr_en) vld_q[k] <= 1'b1;
		end
	end

	// tile bounds and evaluation
	logic [CW-1:0] tminx, tendx, tminy, tendy;
	logic [CW-1:0] x1, x2, y1, y2;
	logic [2*CW-1:0] xn, yn;
	logic          wk_full;

	assign tminx   = CW'(int'(i_idx) * XS);
	assign tendx   = CW'((int'(i_idx) + 1) * XS);
	assign tminy   = CW'(int'(j_idx) * YS);
	assign tendy   = CW'((int'(j_idx) + 1) * YS);
	assign box     = rd_vld_q ? rd_q : {tendx - 1'b1, tminx, tendy - 1'b1, tminy};
	assign x1      = box[4*CW-1:3*CW];
	assign x2      = box[3*CW-1:2*CW];
	assign y1      = box[2*CW-1:CW];
	assign y2      = box[CW-1:0];
	assign wk_full = (cmd.mode == WK_FULL);
	assign xn      = axis_upd(x1, x2, xs_u, xe_u, tminx, tendx,
		i_idx == ilo, i_idx == ihi, is_point, wk_full);
	assign yn      = axis_upd(y1, y2, ys_u, ye_u, tminy, tendy,
		j_idx == jlo, j_idx == jhi, is_point, wk_full);
	assign wbox    = {xn, yn};

	// tile region id, counted from one and masked to seven bits
	logic [KW:0]   kp1;
	logic [KW+7:0] kx;
	logic [43:0]   tile_item;

	assign kp1       = {1'b0, k} + 1'b1;
	assign kx        = (KW + 8)'(kp1);
	assign tile_item = pack_item(kx[6:0], to9(x1), to9(y1), to9(x2), to9(y2), 1'b1);

	// held tile until the next one shows whether it is the last
	logic              pend_v_q;
	logic [43:0]       pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_v_q, out_last_q, out_free;
	logic [43:0]       out_q;

	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
		end else if (cmd.scan_init) begin
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
		end else if (cmd.scan_take) begin
			pend_v_q <= 1'b1;
			cnt_q    <= cnt_q + 1'b1;
		end else if (cmd.emit_fin) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_take) pend_q <= tile_item;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((cmd.scan_take && pend_v_q) || cmd.emit_fin || cmd.emit_glob) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_take && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (cmd.emit_fin) begin
			out_q      <= pend_v_q ? pend_q : '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_glob) begin
			out_q      <= pack_item(7'd0, to9(g_l_q), to9(g_t_q), to9(g_r_q), to9(g_b_q), 1'b1);
			out_last_q <= 1'b1;
		end
	end

	// has_region leaves on tuser, the region fields on tdata
	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, out_q[42:0]};
	assign m_tuser  = out_q[43];
	assign m_tlast  = out_last_q;

	// status to the controller
	assign st.req_type      = req_type_q;
	assign st.point_ok      = (px >= 0) && (px < SW_S) && (py >= 0) && (py < SH_S);
	assign st.rect_ok       = x_ok && y_ok;
	assign st.solid_cand    = solid_cand;
	assign st.tile_full     = (x1 <= tminx) && (x2 >= tendx - 1'b1)
		&& (y1 <= tminy) && (y2 >= tendy - 1'b1);
	assign st.tile_nonempty = (x1 < x2) && (y1 < y2);
	assign st.out_free      = out_free;
	assign st.pend_v        = pend_v_q;
	assign st.cnt_last      = (cnt_q == CNT_W'(MAX_RES - 1));
	assign st.ilo           = ilo;
	assign st.ihi           = ihi;
	assign st.jlo           = jlo;
	assign st.jhi           = jhi;

	// a waiting result is never overwritten
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_take && pend_v_q) |-> out_free)
		else $error("held tile pushed into a busy output register");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_fin || cmd.emit_glob) |-> out_free)
		else $error("final result loaded into a busy output register");
	a_cnt_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_RES)))
		else $error("held tile without a matching result count");
	a_take_more: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_take |=> !cmd.scan_take)
		else $error("two tiles taken in consecutive cycles");

endmodule
`default_nettype wire
